@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit heap allocator
// Item formats, heap block record, scan token and the edit commands that
// the controller broadcasts to the row of block cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  // Default sizes
  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_HEAP_BYTES = 65536;

  // Width of block start and size fields (room for merged and odd blocks)
  localparam int BW = 18;

  // Width of a table slot number, enough for the largest table
  localparam int SW = 10;

  // Register reset values
  localparam logic [7:0]  HDR_RESET   = 8'd40;
  localparam logic [16:0] LIMIT_RESET = 17'h10000;

  // Register indexes
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOHEAP  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_size;
    logic [15:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [1:0]  status;
  } rsp_t;

  // One heap block as held by a cell
  typedef struct packed {
    logic          v;
    logic [BW-1:0] start;
    logic [BW-1:0] size;
    logic          free;
    logic [SW-1:0] slot;   // table slot owning the block
  } blk_t;

  // Scan token walking the cell row
  typedef struct packed {
    logic act;
    logic found;
    logic got;    // block after the hit captured
    blk_t cur;    // hit block
    blk_t prv;    // block before the hit
    blk_t nxt;    // block after the hit
    blk_t lst;    // block of the cell just passed
  } tok_t;

  // Request fields broadcast to all cells during a scan
  typedef struct packed {
    logic        mode;
    logic [15:0] req;
    logic [15:0] addr;
    logic [7:0]  hdr;
  } scan_t;

  typedef enum logic [1:0] {
    EOP_NONE   = 2'd0,
    EOP_WRITE  = 2'd1,
    EOP_INSERT = 2'd2,
    EOP_DELETE = 2'd3
  } edit_op_t;

  typedef struct packed {
    edit_op_t op;
    blk_t     data;
  } edit_t;

endpackage
`default_nettype wire

@@ rtl/ffa_cell.sv @@
// ----------------------------------------------------------------------------
// ffa_cell: one heap block cell
// Holds one block of the address-ordered list, checks the passing scan
// token against it and shifts with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffa_cell
  import ffa_pkg::*;
#(
  parameter int N   = DEF_MAX_BLOCKS,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire blk_t              left,
  input  wire blk_t              right,
  output blk_t                   blk,
  input  wire tok_t              tok_in,
  input  wire logic [$clog2(N)-1:0] tok_pos_in,
  output tok_t                   tok_out,
  output logic [$clog2(N)-1:0]   tok_pos_out,
  input  wire edit_t             ed,
  input  wire logic [$clog2(N)-1:0] ed_pos,
  input  wire scan_t             scan
);

  localparam int IW = $clog2(N);
  localparam logic [IW-1:0] ME = IW'(IDX);

  logic          hit;
  logic [BW:0]   daddr;
  tok_t          tn;
  logic [IW-1:0] pn;

  // Match of this block against the request; a free takes the matching
  // block with the lowest slot when several share one address
  assign daddr = {1'b0, blk.start} + (BW+1)'(scan.hdr);
  always_comb begin
    hit = 1'b0;
    if (tok_in.act && blk.v) begin
      if (scan.mode == MODE_ALLOC) begin
        hit = !tok_in.found && blk.free && (blk.size >= BW'(scan.req));
      end else begin
        hit = (daddr == (BW+1)'(scan.addr)) &&
              (!tok_in.found || (blk.slot < tok_in.cur.slot));
      end
    end
  end

  // Token update: capture hit, previous and next blocks
  always_comb begin
    tn = tok_in;
    pn = tok_pos_in;
    if (tok_in.act) begin
      tn.lst = blk;
      if (hit) begin
        tn.found = 1'b1;
        tn.got   = 1'b0;
        tn.cur   = blk;
        tn.prv   = tok_in.lst;
        tn.nxt   = '0;
        pn       = ME;
      end else if (tok_in.found && !tok_in.got) begin
        tn.nxt = blk;
        tn.got = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out     <= tn;
    tok_pos_out <= pn;
    if (rst) begin
      tok_out.act <= 1'b0;
    end
  end

  // Block storage with write, insert and delete shifts
  always_ff @(posedge clk) begin
    unique case (ed.op)
      EOP_WRITE: begin
        if (ed_pos == ME) blk <= ed.data;
      end
      EOP_INSERT: begin
        if (ed_pos == ME) blk <= ed.data;
        else if (ME > ed_pos) blk <= left;
      end
      EOP_DELETE: begin
        if (ME >= ed_pos) blk <= right;
      end
      default: ;
    endcase
    if (rst) begin
      blk.v <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator with coalescing
// A free of null skips the scan; other items send the scan token through
// every cell once, then take edit steps for a split or merges. One item is
// in work at a time: a new one is taken only after the result of the last
// is registered for output. Reset empties the block list, zeroes the heap
// top and loads header 40 and limit 65536; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_top
  import ffa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rsp_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BLOCKS);
  localparam int LIM = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
  localparam logic [16:0] LIM_V = 17'(LIM);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_EVAL = 8'b0000_0100,
    S_INS  = 8'b0000_1000,
    S_FRN  = 8'b0001_0000,
    S_FRP  = 8'b0010_0000,
    S_FRD  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [7:0]    hdr;
  logic [16:0]   limit;
  logic [16:0]   heap_top;
  logic [CW-1:0] cnt;
  logic [MAX_BLOCKS-1:0] used;
  scan_t         scan;
  tok_t          tok0;
  tok_t          t;
  logic [IW-1:0] tpos;
  rsp_t          res;
  blk_t          ins_blk;
  logic [BW-1:0] merged;
  logic          nfree_r;
  logic          pfree_r;
  logic          ovalid;
  rsp_t          odata;

  blk_t          cblk [MAX_BLOCKS];
  tok_t          tok  [MAX_BLOCKS+1];
  logic [IW-1:0] tpv  [MAX_BLOCKS+1];
  edit_t         ed;
  logic [IW-1:0] ed_pos;

  logic          acc;
  logic          null_free;
  logic [BW-1:0] req_w;
  logic [BW-1:0] diff;
  logic          split_ok;
  logic [17:0]   new_top;
  logic [16:0]   eff_lim;
  logic          over;
  logic          nfree;
  logic          pfree;
  logic [BW-1:0] merged_c;
  logic [IW-1:0] fslot;

  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign null_free = (in_data.mode == MODE_FREE) && (in_data.block_addr == 16'd0);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid;
  assign out_data  = odata;

  // Cell row
  assign tok[0] = tok0;
  assign tpv[0] = '0;
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    blk_t lft, rgt;
    if (i == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid
      assign lft = cblk[i-1];
    end
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_rest
      assign rgt = cblk[i+1];
    end
    ffa_cell #(.N(MAX_BLOCKS), .IDX(i)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .left        (lft),
      .right       (rgt),
      .blk         (cblk[i]),
      .tok_in      (tok[i]),
      .tok_pos_in  (tpv[i]),
      .tok_out     (tok[i+1]),
      .tok_pos_out (tpv[i+1]),
      .ed          (ed),
      .ed_pos      (ed_pos),
      .scan        (scan)
    );
  end

  // Lowest free table slot
  always_comb begin
    fslot = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!used[i]) fslot = IW'(i);
    end
  end

  // Decision arithmetic on the returned token
  always_comb begin
    req_w    = BW'(scan.req);
    diff     = t.cur.size - req_w;
    split_ok = (diff >= (BW'(scan.hdr) + BW'(4))) && (cnt < FULL_CNT);
    new_top  = 18'(heap_top) + 18'(scan.hdr) + 18'(scan.req);
    eff_lim  = (limit < LIM_V) ? limit : LIM_V;
    over     = (new_top > 18'(eff_lim)) ||
               ((18'(heap_top) + 18'(scan.hdr)) > 18'h0FFFF);
    nfree    = t.got && t.nxt.v && t.nxt.free;
    pfree    = t.prv.v && t.prv.free;
    merged_c = t.cur.size + (nfree ? (BW'(scan.hdr) + t.nxt.size) : '0);
  end

  // Edit command to the cell row
  always_comb begin
    ed.op   = EOP_NONE;
    ed.data = '0;
    ed_pos  = '0;
    unique case (state)
      S_EVAL: begin
        if (scan.mode == MODE_ALLOC) begin
          if (t.found) begin
            ed.op   = EOP_WRITE;
            ed_pos  = tpos;
            ed.data = '{v: 1'b1, start: t.cur.start,
                        size: split_ok ? req_w : t.cur.size, free: 1'b0,
                        slot: t.cur.slot};
          end else if (!over && (cnt != FULL_CNT)) begin
            ed.op   = EOP_WRITE;
            ed_pos  = cnt[IW-1:0];
            ed.data = '{v: 1'b1, start: BW'(heap_top), size: req_w, free: 1'b0,
                        slot: SW'(fslot)};
          end
        end else if (t.found) begin
          ed.op   = EOP_WRITE;
          ed_pos  = tpos;
          ed.data = '{v: 1'b1, start: t.cur.start, size: merged_c, free: 1'b1,
                      slot: t.cur.slot};
        end
      end
      S_INS: begin
        ed.op   = EOP_INSERT;
        ed_pos  = tpos + IW'(1);
        ed.data = ins_blk;
      end
      S_FRN: begin
        if (nfree_r) begin
          ed.op  = EOP_DELETE;
          ed_pos = tpos + IW'(1);
        end
      end
      S_FRP: begin
        if (pfree_r) begin
          ed.op   = EOP_WRITE;
          ed_pos  = tpos - IW'(1);
          ed.data = '{v: 1'b1, start: t.prv.start,
                      size: t.prv.size + BW'(scan.hdr) + merged, free: 1'b1,
                      slot: t.prv.slot};
        end
      end
      S_FRD: begin
        ed.op  = EOP_DELETE;
        ed_pos = tpos;
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr   <= HDR_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADER: hdr   <= cfg_data[7:0];
        REG_LIMIT:  limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller
  always_ff @(posedge clk) begin
    tok0 <= '0;
    if (ovalid && out_ready) ovalid <= 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          scan <= '{mode: in_data.mode, req: in_data.request_size,
                    addr: in_data.block_addr, hdr: hdr};
          if (null_free) begin
            res   <= '{result_addr: 16'd0, status: ST_OK};
            state <= S_FIN;
          end else begin
            tok0.act <= 1'b1;
            state    <= S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tok[MAX_BLOCKS].act) begin
          t     <= tok[MAX_BLOCKS];
          tpos  <= tpv[MAX_BLOCKS];
          state <= S_EVAL;
        end
      end
      S_EVAL: begin
        state <= S_FIN;
        res   <= '{result_addr: 16'd0, status: ST_OK};
        if (scan.mode == MODE_ALLOC) begin
          if (t.found) begin
            res.result_addr <= t.cur.start[15:0] + 16'(scan.hdr);
            ins_blk <= '{v: 1'b1, start: t.cur.start + BW'(scan.hdr) + req_w,
                         size: diff - BW'(scan.hdr), free: 1'b1,
                         slot: SW'(fslot)};
            if (split_ok) begin
              cnt         <= cnt + CW'(1);
              used[fslot] <= 1'b1;
              state       <= S_INS;
            end
          end else if (over) begin
            res.status <= ST_NOHEAP;
          end else if (cnt == FULL_CNT) begin
            res.status <= ST_FULL;
          end else begin
            res.result_addr <= heap_top[15:0] + 16'(scan.hdr);
            heap_top    <= new_top[16:0];
            cnt         <= cnt + CW'(1);
            used[fslot] <= 1'b1;
          end
        end else if (!t.found) begin
          res.status <= ST_UNKNOWN;
        end else begin
          merged  <= merged_c;
          nfree_r <= nfree;
          pfree_r <= pfree;
          state   <= S_FRN;
        end
      end
      S_INS: begin
        state <= S_FIN;
      end
      S_FRN: begin
        if (nfree_r) begin
          cnt                     <= cnt - CW'(1);
          used[t.nxt.slot[IW-1:0]] <= 1'b0;
        end
        state <= S_FRP;
      end
      S_FRP: begin
        state <= pfree_r ? S_FRD : S_FIN;
      end
      S_FRD: begin
        cnt                     <= cnt - CW'(1);
        used[t.cur.slot[IW-1:0]] <= 1'b0;
        state                   <= S_FIN;
      end
      S_FIN: begin
        if (!ovalid || out_ready) begin
          ovalid <= 1'b1;
          odata  <= res;
          state  <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state    <= S_IDLE;
      ovalid   <= 1'b0;
      heap_top <= '0;
      cnt      <= '0;
      used     <= '0;
      tok0.act <= 1'b0;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT)
    else $error("block count above table size");

  a_tok_scan: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_BLOCKS].act |-> (state == S_SCAN))
    else $error("scan token returned outside scan");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN || state == S_FIN))
    else $error("accepted item not started");

endmodule
`default_nettype wire
